// ----- hw/rtl/tmwf_pkg.sv -----
// shared types and constants of the triangle maze wall follower
package tmwf_pkg;

	localparam int ADDR_W = 12;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	localparam logic [6:0] MAX_ROWS = 7'd64;
	localparam logic [6:0] MAX_COLS = 7'd64;

	typedef logic [1:0] op_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [2:0] mask_t;
	typedef logic [1:0] dir_t;
	typedef logic [2:0] status_t;
	typedef logic [2:0] cfg_index_t;
	typedef logic [6:0] cfg_data_t;

	localparam op_t OP_LOAD = 2'd0;
	localparam op_t OP_RESTART = 2'd1;
	localparam op_t OP_ADVANCE = 2'd2;

	localparam cfg_index_t CFG_NUM_ROWS = 3'd0;
	localparam cfg_index_t CFG_NUM_COLS = 3'd1;
	localparam cfg_index_t CFG_START_ROW = 3'd2;
	localparam cfg_index_t CFG_START_COL = 3'd3;
	localparam cfg_index_t CFG_HAND = 3'd4;

	localparam dir_t DIR_LEFT = 2'd0;
	localparam dir_t DIR_UP = 2'd1;
	localparam dir_t DIR_RIGHT = 2'd2;
	localparam dir_t DIR_DOWN = 2'd3;

	localparam status_t ST_MOVED = 3'd0;
	localparam status_t ST_EXIT = 3'd1;
	localparam status_t ST_BAD = 3'd2;
	localparam status_t ST_STUCK = 3'd3;
	localparam status_t ST_IDLE = 3'd4;

	typedef struct packed {
		logic [6:0] num_rows;
		logic [6:0] num_cols;
		logic [5:0] start_row;
		logic [5:0] start_col;
		logic       hand;
	} cfg_t;

	typedef struct packed {
		logic [6:0] row_out;
		logic [6:0] col_out;
		status_t    status;
	} result_t;

	// result handoff between the walker and the output stage
	typedef struct packed {
		logic    valid;
		result_t data;
	} res_req_t;

endpackage

// ----- hw/rtl/tmwf_channels.sv -----
// channel interfaces: input items, result items and configuration writes
interface tmwf_item_if;
	logic             valid;
	logic             ready;
	tmwf_pkg::op_t    operation;
	tmwf_pkg::addr_t  cell_index;
	tmwf_pkg::mask_t  cell_value;
	modport source(output valid, operation, cell_index, cell_value, input ready);
	modport sink(input valid, operation, cell_index, cell_value, output ready);
endinterface

interface tmwf_result_if;
	logic                valid;
	logic                ready;
	logic [6:0]          row_out;
	logic [6:0]          col_out;
	tmwf_pkg::status_t   status;
	modport source(output valid, row_out, col_out, status, input ready);
	modport sink(input valid, row_out, col_out, status, output ready);
endinterface

interface tmwf_cfg_if;
	logic                   valid;
	logic                   ready;
	tmwf_pkg::cfg_index_t   index;
	tmwf_pkg::cfg_data_t    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tmwf_cell_mem.sv -----
// cell wall store: one write port, one registered read port
module tmwf_cell_mem (
	input  logic            clk,
	input  logic            we,
	input  tmwf_pkg::addr_t waddr,
	input  tmwf_pkg::mask_t wdata,
	input  tmwf_pkg::addr_t raddr,
	output tmwf_pkg::mask_t rdata
);

	tmwf_pkg::mask_t mem [tmwf_pkg::STORE_DEPTH];
	tmwf_pkg::mask_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/tmwf_cfg_regs.sv -----
// configuration register file
module tmwf_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	tmwf_cfg_if.sink      cfg,
	output tmwf_pkg::cfg_t regs
);

	tmwf_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.num_rows  <= 7'd1;
			regs_q.num_cols  <= 7'd1;
			regs_q.start_row <= 6'd0;
			regs_q.start_col <= 6'd0;
			regs_q.hand      <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				tmwf_pkg::CFG_NUM_ROWS:  regs_q.num_rows  <= cfg.data;
				tmwf_pkg::CFG_NUM_COLS:  regs_q.num_cols  <= cfg.data;
				tmwf_pkg::CFG_START_ROW: regs_q.start_row <= cfg.data[5:0];
				tmwf_pkg::CFG_START_COL: regs_q.start_col <= cfg.data[5:0];
				tmwf_pkg::CFG_HAND:      regs_q.hand      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ----- hw/rtl/tmwf_walker.sv -----
// walk sequencer: decodes items, drives the cell store and turns the walker
module tmwf_walker (
	input  logic              clk,
	input  logic              arst_n,
	tmwf_item_if.sink         item,
	input  tmwf_pkg::cfg_t    cfg,
	output logic              mem_we,
	output tmwf_pkg::addr_t   mem_waddr,
	output tmwf_pkg::mask_t   mem_wdata,
	output tmwf_pkg::addr_t   mem_raddr,
	input  tmwf_pkg::mask_t   mem_rdata,
	output tmwf_pkg::res_req_t res,
	input  logic              res_take
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADDR = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_TURN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic              walk_q;
	logic [5:0]        cur_row_q;
	logic [5:0]        cur_col_q;
	tmwf_pkg::dir_t    heading_q;
	logic [1:0]        turn_q;
	tmwf_pkg::addr_t   addr_s1;
	tmwf_pkg::result_t res_q;

	logic              accept;
	logic              geom_ok;
	logic              pos_ok;
	logic [2:0]        entry_dir;
	logic [12:0]       addr_full;
	logic              odd;
	logic              walled;
	logic              exits;
	logic [5:0]        next_row;
	logic [5:0]        next_col;
	tmwf_pkg::dir_t    dir_moved;
	tmwf_pkg::dir_t    dir_turned;

	// skip the side that a cell of this orientation lacks
	function automatic tmwf_pkg::dir_t fix_dir(input tmwf_pkg::dir_t d, input logic odd_cell,
			input logic hand);
		tmwf_pkg::dir_t back;
		back = hand ? 2'd3 : 2'd1;
		if ((odd_cell && d == tmwf_pkg::DIR_UP) || (!odd_cell && d == tmwf_pkg::DIR_DOWN)) begin
			return d + back;
		end
		return d;
	endfunction

	// first heading from the entry cell position, 4 means no usable edge
	function automatic logic [2:0] start_dir(input tmwf_pkg::cfg_t c);
		logic       odd_cell;
		logic [6:0] r;
		logic [6:0] k;
		logic [6:0] last_r;
		logic [6:0] last_c;
		odd_cell = c.start_row[0] ^ c.start_col[0];
		r = {1'b0, c.start_row};
		k = {1'b0, c.start_col};
		last_r = c.num_rows - 7'd1;
		last_c = c.num_cols - 7'd1;
		if (r >= c.num_rows || k >= c.num_cols) begin
			return 3'd4;
		end
		if (c.hand) begin
			if (k == 7'd0 && r[0]) return {1'b0, tmwf_pkg::DIR_RIGHT};
			if (k == 7'd0) return {1'b0, tmwf_pkg::DIR_DOWN};
			if (k == last_c && !odd_cell) return {1'b0, tmwf_pkg::DIR_UP};
			if (k == last_c) return {1'b0, tmwf_pkg::DIR_LEFT};
			if (r == 7'd0) return {1'b0, tmwf_pkg::DIR_LEFT};
			if (r == last_r) return {1'b0, tmwf_pkg::DIR_RIGHT};
		end else begin
			if (k == 7'd0 && r[0]) return {1'b0, tmwf_pkg::DIR_UP};
			if (k == 7'd0) return {1'b0, tmwf_pkg::DIR_RIGHT};
			if (k == last_c && !odd_cell) return {1'b0, tmwf_pkg::DIR_LEFT};
			if (k == last_c) return {1'b0, tmwf_pkg::DIR_DOWN};
			if (r == 7'd0) return {1'b0, tmwf_pkg::DIR_RIGHT};
			if (r == last_r) return {1'b0, tmwf_pkg::DIR_LEFT};
		end
		return 3'd4;
	endfunction

	assign item.ready = (state_q == S_IDLE);
	assign accept = item.valid && item.ready;

	assign mem_we = accept && (item.operation == tmwf_pkg::OP_LOAD);
	assign mem_waddr = item.cell_index;
	assign mem_wdata = item.cell_value;
	assign mem_raddr = addr_s1;

	assign geom_ok = (cfg.num_rows >= 7'd1) && (cfg.num_rows <= tmwf_pkg::MAX_ROWS) &&
		(cfg.num_cols >= 7'd1) && (cfg.num_cols <= tmwf_pkg::MAX_COLS);
	assign pos_ok = ({1'b0, cur_row_q} < cfg.num_rows) && ({1'b0, cur_col_q} < cfg.num_cols);
	assign entry_dir = start_dir(cfg);

	// rows and columns are capped at the maximum, so the address fits the store
	assign addr_full = 13'(cur_row_q * cfg.num_cols) + {7'd0, cur_col_q};

	assign odd = cur_row_q[0] ^ cur_col_q[0];

	always_comb begin
		walled = mem_rdata[2];
		exits = 1'b0;
		next_row = cur_row_q;
		next_col = cur_col_q;
		case (heading_q)
			tmwf_pkg::DIR_LEFT: begin
				walled = mem_rdata[0];
				exits = (cur_col_q == 6'd0);
				next_col = cur_col_q - 6'd1;
			end
			tmwf_pkg::DIR_RIGHT: begin
				walled = mem_rdata[1];
				exits = (({1'b0, cur_col_q} + 7'd1) >= cfg.num_cols);
				next_col = cur_col_q + 6'd1;
			end
			tmwf_pkg::DIR_UP: begin
				exits = (cur_row_q == 6'd0);
				next_row = cur_row_q - 6'd1;
			end
			default: begin
				exits = (({1'b0, cur_row_q} + 7'd1) >= cfg.num_rows);
				next_row = cur_row_q + 6'd1;
			end
		endcase
		// every move flips the orientation of the cell
		dir_moved = fix_dir(heading_q + (cfg.hand ? 2'd1 : 2'd3), !odd, cfg.hand);
		dir_turned = fix_dir(heading_q + (cfg.hand ? 2'd3 : 2'd1), odd, cfg.hand);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			walk_q <= 1'b0;
			cur_row_q <= 6'd0;
			cur_col_q <= 6'd0;
			heading_q <= tmwf_pkg::DIR_LEFT;
			turn_q <= 2'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && item.operation == tmwf_pkg::OP_RESTART) begin
						if (geom_ok && !entry_dir[2]) begin
							cur_row_q <= cfg.start_row;
							cur_col_q <= cfg.start_col;
							heading_q <= entry_dir[1:0];
							walk_q <= 1'b1;
						end else begin
							walk_q <= 1'b0;
							state_q <= S_EMIT;
						end
					end else if (accept && item.operation == tmwf_pkg::OP_ADVANCE) begin
						if (!walk_q) begin
							state_q <= S_EMIT;
						end else if (!geom_ok || !pos_ok) begin
							walk_q <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_ADDR;
						end
					end
				end
				S_ADDR: begin
					state_q <= S_READ;
				end
				S_READ: begin
					turn_q <= 2'd0;
					state_q <= S_TURN;
				end
				S_TURN: begin
					if (!walled) begin
						if (exits) begin
							walk_q <= 1'b0;
						end else begin
							cur_row_q <= next_row;
							cur_col_q <= next_col;
							heading_q <= dir_moved;
						end
						state_q <= S_EMIT;
					end else begin
						heading_q <= dir_turned;
						turn_q <= turn_q + 2'd1;
						if (turn_q == 2'd3) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_ADDR) begin
			addr_s1 <= addr_full[tmwf_pkg::ADDR_W-1:0];
		end
		if (state_q == S_IDLE && accept) begin
			res_q.row_out <= 7'd0;
			res_q.col_out <= 7'd0;
			res_q.status <= (item.operation == tmwf_pkg::OP_RESTART) ? tmwf_pkg::ST_BAD :
				tmwf_pkg::ST_IDLE;
		end
		if (state_q == S_TURN) begin
			if (!walled) begin
				res_q.row_out <= {1'b0, cur_row_q} + 7'd1;
				res_q.col_out <= {1'b0, cur_col_q} + 7'd1;
				res_q.status <= exits ? tmwf_pkg::ST_EXIT : tmwf_pkg::ST_MOVED;
			end else begin
				res_q.row_out <= 7'd0;
				res_q.col_out <= 7'd0;
				res_q.status <= tmwf_pkg::ST_STUCK;
			end
		end
	end

	assign res.valid = (state_q == S_EMIT);
	assign res.data = res_q;

endmodule

// ----- hw/rtl/triangle_maze_wall_follower.sv -----
// top level of the triangle maze wall follower
// usage:
//   cfg    - register writes (index, data), always ready; write only while idle
//   item   - operation plus cell index and wall mask; load, restart or advance
//   result - one-based row and column of the cell left, and a status code
// a load writes the cell store and produces no result; the next item may follow
// in the next cycle. a restart reports only a bad start.
// an advance while walking at a valid position computes the store address (one
// multiply), reads the cell store once and then tests one heading per cycle
// against the registered wall mask, up to four tests, and hands the result to
// the output register; other advances report idle. the next item is taken as
// soon as the result sits in the output register, even if it is not yet taken.
// reset clears the walker (not walking, heading left) and the registers to
// their defaults; the cell store is not cleared and must be loaded before use.
// while the receiver stalls the result is held and the walker waits with its
// next result, taking no further items.
module triangle_maze_wall_follower (
	input  logic         clk,
	input  logic         arst_n,
	tmwf_cfg_if.sink     cfg,
	tmwf_item_if.sink    item,
	tmwf_result_if.source result
);

	tmwf_pkg::cfg_t     regs;
	logic               mem_we;
	tmwf_pkg::addr_t    mem_waddr;
	tmwf_pkg::mask_t    mem_wdata;
	tmwf_pkg::addr_t    mem_raddr;
	tmwf_pkg::mask_t    mem_rdata;
	tmwf_pkg::res_req_t res;
	logic               res_take;
	logic               out_valid_q;
	tmwf_pkg::result_t  out_q;

	tmwf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tmwf_cell_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tmwf_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (regs),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res       (res),
		.res_take  (res_take)
	);

	// output register frees the walker once the result is parked here
	assign res_take = res.valid && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res.data;
		end
	end

	assign result.valid = out_valid_q;
	assign result.row_out = out_q.row_out;
	assign result.col_out = out_q.col_out;
	assign result.status = out_q.status;

endmodule
